@@ rtl/lvsc_pkg.sv @@
// Shared types and constants for the line vector steering classifier.
package lvsc_pkg;

	localparam int unsigned CoordW  = 8;
	localparam int unsigned AmountW = 7;
	localparam int unsigned SpeedW  = 7;
	localparam int unsigned CountW  = 2;
	localparam int unsigned AddrW   = 3;
	localparam int unsigned DataW   = 32;

	// Steering direction codes.
	typedef enum logic [1:0] {
		DIR_STRAIGHT = 2'd0,
		DIR_LEFT     = 2'd1,
		DIR_RIGHT    = 2'd2
	} steer_dir_t;

	// Register index, taken from paddr[2].
	typedef enum logic {
		REG_BASE_SPEED   = 1'b0,
		REG_DRIVE_ENABLE = 1'b1
	} reg_idx_t;

	localparam logic [SpeedW-1:0]  BaseSpeedReset = 7'd20;

	// Turn amounts chosen by the first vector of a frame.
	localparam logic [AmountW-1:0] TurnSharp  = 7'd75;
	localparam logic [AmountW-1:0] TurnMid    = 7'd65;
	localparam logic [AmountW-1:0] TurnCross  = 7'd60;
	localparam logic [AmountW-1:0] TurnSoft   = 7'd40;

	// Speed thresholds on the turn amount and the speeds they select.
	localparam logic [AmountW-1:0] TurnFast   = 7'd75;
	localparam logic [AmountW-1:0] TurnMed    = 7'd50;
	localparam logic [AmountW-1:0] TurnSlow   = 7'd25;
	localparam logic [SpeedW-1:0]  Speed5     = 7'd5;
	localparam logic [SpeedW-1:0]  Speed10    = 7'd10;
	localparam logic [SpeedW-1:0]  Speed15    = 7'd15;

	// Result payload.
	typedef struct packed {
		logic               steer_valid;
		steer_dir_t         steer_dir;
		logic [AmountW-1:0] steer_amount;
		logic               speed_valid;
		logic [SpeedW-1:0]  speed_value;
		logic               finish_line;
	} cmd_t;

endpackage

@@ rtl/lvsc_vec_if.sv @@
// Channel interface carrying one line vector per transaction.
interface lvsc_vec_if;
	import lvsc_pkg::*;

	logic              valid;
	logic              ready;
	logic [CoordW-1:0] ax;
	logic [CoordW-1:0] ay;
	logic [CoordW-1:0] bx;
	logic [CoordW-1:0] by;
	logic              frame_first;
	logic              frame_last;

	modport source (output valid, ax, ay, bx, by, frame_first, frame_last, input ready);
	modport sink   (input valid, ax, ay, bx, by, frame_first, frame_last, output ready);
endinterface

@@ rtl/lvsc_cmd_if.sv @@
// Channel interface carrying one steering and speed command per transaction.
interface lvsc_cmd_if;
	import lvsc_pkg::*;

	logic               valid;
	logic               ready;
	logic               steer_valid;
	logic [1:0]         steer_dir;
	logic [AmountW-1:0] steer_amount;
	logic               speed_valid;
	logic [SpeedW-1:0]  speed_value;
	logic               finish_line;

	modport source (output valid, steer_valid, steer_dir, steer_amount, speed_valid,
		speed_value, finish_line, input ready);
	modport sink   (input valid, steer_valid, steer_dir, steer_amount, speed_valid,
		speed_value, finish_line, output ready);
endinterface

@@ rtl/line_vector_steering_classifier.sv @@
// Top level of the line vector steering classifier.
//
//  channel   direction  handshake      content
//  vec_in    in         valid/ready    ax, ay, bx, by, frame_first, frame_last
//  cmd_out   out        valid/ready    steer and speed command, finish_line
//  apb       in         psel/penable   base_speed (0x0), drive_enable (0x4)
//
// One vector is accepted per cycle while input ready is high; its command
// passes through the input register, then the result register. The frame
// state is updated as a vector moves from the input register into the
// result register, so the next vector sees it at once. A stalled output
// holds the result register and the input register, and input ready drops
// only when both are full. Reset clears the frame state, the registers to
// their defaults and both valid flags.
module line_vector_steering_classifier
	import lvsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	lvsc_vec_if.sink         vec_in,
	lvsc_cmd_if.source       cmd_out
);

	// Configuration registers.
	logic [SpeedW-1:0] base_speed_q;
	logic              drive_enable_q;
	reg_idx_t          reg_idx;

	// Input register.
	logic              valid_s1;
	logic [CoordW-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic              first_s1, last_s1;

	// Frame state.
	logic [AmountW-1:0] turn_amount_q;
	logic               turn_left_q;
	logic [CountW-1:0]  hcount_q;
	logic               lap_done_q;

	// Result register.
	logic valid_s2;
	cmd_t cmd_s2;

	// Combinational step.
	logic               advance;
	logic [CoordW-1:0]  dy, dx, xs, xe;
	logic [CoordW:0]    ysum;
	logic               horiz;
	logic [CountW-1:0]  hcount_base, hcount_next;
	logic               finish;
	logic               lap_next;
	logic [AmountW-1:0] rule_amount, turn_next;
	logic               rule_left, left_next;
	cmd_t               cmd_next;

	// APB port: always ready, register chosen by paddr[2].
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (reg_idx)
			REG_BASE_SPEED:   prdata = DataW'(base_speed_q);
			REG_DRIVE_ENABLE: prdata = DataW'(drive_enable_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q   <= BaseSpeedReset;
			drive_enable_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_BASE_SPEED:   base_speed_q   <= pwdata[SpeedW-1:0];
				REG_DRIVE_ENABLE: drive_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Handshake: the input register moves on when the result register is free.
	assign advance      = valid_s1 && (!valid_s2 || cmd_out.ready);
	assign vec_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (vec_in.ready) begin
			valid_s1 <= vec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (vec_in.valid && vec_in.ready) begin
			ax_s1    <= vec_in.ax;
			ay_s1    <= vec_in.ay;
			bx_s1    <= vec_in.bx;
			by_s1    <= vec_in.by;
			first_s1 <= vec_in.frame_first;
			last_s1  <= vec_in.frame_last;
		end
	end

	// Orientation: the start is the endpoint nearer the camera (larger y).
	always_comb begin
		dy   = (ay_s1 >= by_s1) ? (ay_s1 - by_s1) : (by_s1 - ay_s1);
		dx   = (ax_s1 >= bx_s1) ? (ax_s1 - bx_s1) : (bx_s1 - ax_s1);
		xs   = (ay_s1 >= by_s1) ? ax_s1 : bx_s1;
		xe   = (ay_s1 >= by_s1) ? bx_s1 : ax_s1;
		ysum = {1'b0, ay_s1} + {1'b0, by_s1};
	end

	// Horizontal line test and the finish-line count.
	always_comb begin
		horiz = (dy < 8'd10) && ((dy == '0) || ({dy, 1'b0} < {1'b0, dx}))
			&& (ax_s1 > 8'd10) && (bx_s1 > 8'd10) && (ax_s1 < 8'd60) && (bx_s1 < 8'd60);
		hcount_base = first_s1 ? '0 : hcount_q;
		hcount_next = hcount_base;
		if (horiz && (hcount_base != '1)) begin
			hcount_next = hcount_base + 1'b1;
		end
		finish   = horiz && (hcount_next == CountW'(2));
		lap_next = lap_done_q || finish;
	end

	// Turn rules for the first vector of a frame; later rules take precedence.
	always_comb begin
		rule_amount = '0;
		rule_left   = 1'b0;
		if ((dx < 8'd10) && (dy > 8'd40)) begin
			if (xs > 8'd38) begin
				rule_amount = (xs < 8'd60) ? TurnMid : TurnSoft;
				rule_left   = 1'b1;
			end else begin
				rule_amount = (xs > 8'd18) ? TurnMid : TurnSoft;
				rule_left   = 1'b0;
			end
		end
		if ((dy > 8'd20) && (dx > 8'd10)) begin
			if (xs >= xe) begin
				if (xs < 8'd70) begin
					rule_amount = (dx > 8'd40) ? TurnSharp : TurnSoft;
					rule_left   = 1'b1;
				end
			end else begin
				if (xs > 8'd10) begin
					rule_amount = (dx > 8'd40) ? TurnSharp : TurnSoft;
				end
				rule_left = 1'b0;
			end
		end
		if ((dx > 8'd30) && (dy > 8'd10)) begin
			rule_amount = TurnCross;
			rule_left   = (xs > xe);
		end
		turn_next = first_s1 ? rule_amount : turn_amount_q;
		left_next = first_s1 ? rule_left : turn_left_q;
	end

	// Command assembly: finish speed first, the last vector may override it.
	always_comb begin
		cmd_next             = '0;
		cmd_next.steer_dir   = DIR_STRAIGHT;
		cmd_next.finish_line = finish;
		if (finish) begin
			cmd_next.speed_valid = 1'b1;
			cmd_next.speed_value = (ysum[CoordW:1] > 8'd25) ? Speed5 : Speed10;
		end
		if (last_s1) begin
			if (turn_next == '0) begin
				if (drive_enable_q) begin
					cmd_next.steer_valid = 1'b1;
					if (!lap_next) begin
						cmd_next.speed_valid = 1'b1;
						cmd_next.speed_value = base_speed_q;
					end
				end
			end else begin
				cmd_next.steer_valid  = 1'b1;
				cmd_next.steer_dir    = left_next ? DIR_LEFT : DIR_RIGHT;
				cmd_next.steer_amount = turn_next;
				if (!lap_next && drive_enable_q) begin
					priority if (turn_next >= TurnFast) begin
						cmd_next.speed_valid = 1'b1;
						cmd_next.speed_value = Speed5;
					end else if (turn_next >= TurnMed) begin
						cmd_next.speed_valid = 1'b1;
						cmd_next.speed_value = Speed10;
					end else if (turn_next >= TurnSlow) begin
						cmd_next.speed_valid = 1'b1;
						cmd_next.speed_value = Speed15;
					end
				end
			end
		end
	end

	// Frame state update as a vector completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_amount_q <= '0;
			turn_left_q   <= 1'b0;
			hcount_q      <= '0;
			lap_done_q    <= 1'b0;
		end else if (advance) begin
			turn_amount_q <= turn_next;
			turn_left_q   <= left_next;
			hcount_q      <= hcount_next;
			lap_done_q    <= lap_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (cmd_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s2 <= cmd_next;
		end
	end

	assign cmd_out.valid        = valid_s2;
	assign cmd_out.steer_valid  = cmd_s2.steer_valid;
	assign cmd_out.steer_dir    = cmd_s2.steer_dir;
	assign cmd_out.steer_amount = cmd_s2.steer_amount;
	assign cmd_out.speed_valid  = cmd_s2.speed_valid;
	assign cmd_out.speed_value  = cmd_s2.speed_value;
	assign cmd_out.finish_line  = cmd_s2.finish_line;

endmodule
